@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the limiter RTL.
// Each check samples on the rising edge of clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property while out of reset.
`define DTBL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property on every edge, reset included.
`define DTBL_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/dtbl_pkg.sv @@
`timescale 1ns / 1ps
package dtbl_pkg;

	localparam int LEVEL_W  = 32;
	localparam int TICK_W   = 32;
	localparam int CFG_W    = 31;
	localparam int ACTION_W = 2;
	localparam int CFG_IDX_W = 4;

	localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_READ_RATE  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_READ_CEIL  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WRITE_RATE = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WRITE_CEIL = 4'd3;

	localparam logic [CFG_W-1:0] CFG_RESET_VALUE = 31'd65536;
	localparam logic signed [LEVEL_W-1:0] LEVEL_RESET = 32'sd65536;
	localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = 32'sh7fff_ffff;
	localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic [CFG_W-1:0] read_refill;
		logic [CFG_W-1:0] read_ceil;
		logic [CFG_W-1:0] write_refill;
		logic [CFG_W-1:0] write_ceil;
	} cfg_regs_t;

	typedef struct packed {
		logic refill;
		logic take;
	} bucket_op_t;

endpackage

@@ rtl/core/dtbl_item_if.sv @@
`timescale 1ns / 1ps
interface dtbl_item_if;
	logic                                 valid;
	logic                                 ready;
	logic [dtbl_pkg::ACTION_W-1:0]        action;
	logic [dtbl_pkg::TICK_W-1:0]          tick_now;
	logic signed [dtbl_pkg::LEVEL_W-1:0]  amount;

	modport source (output valid, action, tick_now, amount, input ready);
	modport sink (input valid, action, tick_now, amount, output ready);
endinterface

@@ rtl/core/dtbl_result_if.sv @@
`timescale 1ns / 1ps
interface dtbl_result_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [dtbl_pkg::LEVEL_W-1:0]  read_level;
	logic signed [dtbl_pkg::LEVEL_W-1:0]  write_level;
	logic                                 saturated;

	modport source (output valid, read_level, write_level, saturated, input ready);
	modport sink (input valid, read_level, write_level, saturated, output ready);
endinterface

@@ rtl/core/dtbl_cfg_if.sv @@
`timescale 1ns / 1ps
interface dtbl_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [dtbl_pkg::CFG_IDX_W-1:0]     index;
	logic [31:0]                        data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/dtbl_cfg.sv @@
`timescale 1ns / 1ps
module dtbl_cfg (
	input  logic                clk,
	input  logic                arst_n,
	dtbl_cfg_if.sink            cfg,
	output dtbl_pkg::cfg_regs_t regs
);

	dtbl_pkg::cfg_regs_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	// Keep the low 31 bits of each write; drop writes to unknown indexes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.read_refill  <= dtbl_pkg::CFG_RESET_VALUE;
			regs_q.read_ceil    <= dtbl_pkg::CFG_RESET_VALUE;
			regs_q.write_refill <= dtbl_pkg::CFG_RESET_VALUE;
			regs_q.write_ceil   <= dtbl_pkg::CFG_RESET_VALUE;
		end else if (cfg.valid) begin
			case (cfg.index)
				dtbl_pkg::REG_READ_RATE:  regs_q.read_refill  <= cfg.data[dtbl_pkg::CFG_W-1:0];
				dtbl_pkg::REG_READ_CEIL:  regs_q.read_ceil    <= cfg.data[dtbl_pkg::CFG_W-1:0];
				dtbl_pkg::REG_WRITE_RATE: regs_q.write_refill <= cfg.data[dtbl_pkg::CFG_W-1:0];
				dtbl_pkg::REG_WRITE_CEIL: regs_q.write_ceil   <= cfg.data[dtbl_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

@@ rtl/core/dtbl_bucket.sv @@
`timescale 1ns / 1ps
module dtbl_bucket (
	input  dtbl_pkg::bucket_op_t                op,
	input  logic signed [dtbl_pkg::LEVEL_W-1:0] level,
	input  logic [dtbl_pkg::CFG_W-1:0]          elapsed,
	input  logic [dtbl_pkg::CFG_W-1:0]          rate,
	input  logic [dtbl_pkg::CFG_W-1:0]          ceiling,
	input  logic signed [dtbl_pkg::LEVEL_W-1:0] amount,
	output logic signed [dtbl_pkg::LEVEL_W-1:0] level_next,
	output logic                                sat
);

	logic [2*dtbl_pkg::CFG_W-1:0]        product;
	logic signed [dtbl_pkg::LEVEL_W+1:0] sum;
	logic signed [dtbl_pkg::LEVEL_W:0]   diff;
	logic                                over_ceil;
	logic                                diff_ovf;

	assign product = elapsed * rate;

	// A product at or above 2^32 always lands past any ceiling.
	assign sum = {{2{level[dtbl_pkg::LEVEL_W-1]}}, level}
		+ $signed({2'b00, product[dtbl_pkg::LEVEL_W-1:0]});
	assign over_ceil = (|product[2*dtbl_pkg::CFG_W-1:dtbl_pkg::LEVEL_W])
		|| (sum > $signed({3'b000, ceiling}));

	assign diff = {level[dtbl_pkg::LEVEL_W-1], level}
		- {amount[dtbl_pkg::LEVEL_W-1], amount};
	assign diff_ovf = diff[dtbl_pkg::LEVEL_W] != diff[dtbl_pkg::LEVEL_W-1];
	assign sat = op.take && diff_ovf;

	always_comb begin
		level_next = level;
		if (op.refill) begin
			level_next = over_ceil ? $signed({1'b0, ceiling}) : sum[dtbl_pkg::LEVEL_W-1:0];
		end else if (op.take) begin
			if (diff_ovf) begin
				level_next = diff[dtbl_pkg::LEVEL_W] ? dtbl_pkg::LEVEL_MIN : dtbl_pkg::LEVEL_MAX;
			end else begin
				level_next = diff[dtbl_pkg::LEVEL_W-1:0];
			end
		end
	end

endmodule

@@ rtl/core/dual_token_bucket_limiter_unit.sv @@
`timescale 1ns / 1ps
// Each item is registered in s1 and its result in s2, one item per cycle
// unless result.ready stalls s2; the loop through the level and last-tick
// registers (subtract, 31x31 multiply, add and clamp) sets that rate.
// Reset (arst_n low, asynchronous): all four config registers and both
// levels go to 65536, last tick to zero, and both pipeline stages empty.
module dual_token_bucket_limiter_unit (
	input  logic            clk,
	input  logic            arst_n,
	dtbl_item_if.sink       item,
	dtbl_result_if.source   result,
	dtbl_cfg_if.sink        cfg
);

	// Configuration registers.
	dtbl_pkg::cfg_regs_t regs;

	dtbl_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// Input stage: one registered item.
	logic                                valid_s1;
	logic [dtbl_pkg::ACTION_W-1:0]       action_s1;
	logic [dtbl_pkg::TICK_W-1:0]         tick_s1;
	logic signed [dtbl_pkg::LEVEL_W-1:0] amount_s1;

	// Result stage.
	logic                                valid_s2;
	logic signed [dtbl_pkg::LEVEL_W-1:0] read_level_s2;
	logic signed [dtbl_pkg::LEVEL_W-1:0] write_level_s2;
	logic                                sat_s2;

	// Bucket state.
	logic signed [dtbl_pkg::LEVEL_W-1:0] read_tokens_q;
	logic signed [dtbl_pkg::LEVEL_W-1:0] write_tokens_q;
	logic [dtbl_pkg::TICK_W-1:0]         last_tick_q;

	logic                                advance;
	logic [dtbl_pkg::TICK_W-1:0]         elapsed;
	logic                                refill_ok;
	dtbl_pkg::bucket_op_t                read_op;
	dtbl_pkg::bucket_op_t                write_op;
	logic signed [dtbl_pkg::LEVEL_W-1:0] read_next;
	logic signed [dtbl_pkg::LEVEL_W-1:0] write_next;
	logic                                read_sat;
	logic                                write_sat;

	// The item in s1 moves on whenever the result register is free or is
	// being drained this cycle; s1 refills in the same cycle it empties.
	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	// Payload needs no reset; capture on every transfer.
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			action_s1 <= item.action;
			tick_s1   <= item.tick_now;
			amount_s1 <= item.amount;
		end
	end

	// Elapsed ticks wrap mod 2^32. Refill only for a forward step of
	// 1 .. 2^31-1; zero or a backward step leaves everything alone.
	assign elapsed   = tick_s1 - last_tick_q;
	assign refill_ok = (elapsed != '0) && !elapsed[dtbl_pkg::TICK_W-1];

	always_comb begin
		read_op.refill  = (action_s1 == dtbl_pkg::ACT_TICK) && refill_ok;
		read_op.take    = (action_s1 == dtbl_pkg::ACT_READ);
		write_op.refill = (action_s1 == dtbl_pkg::ACT_TICK) && refill_ok;
		write_op.take   = (action_s1 == dtbl_pkg::ACT_WRITE);
	end

	dtbl_bucket u_read_bucket (
		.op         (read_op),
		.level      (read_tokens_q),
		.elapsed    (elapsed[dtbl_pkg::CFG_W-1:0]),
		.rate       (regs.read_refill),
		.ceiling    (regs.read_ceil),
		.amount     (amount_s1),
		.level_next (read_next),
		.sat        (read_sat)
	);

	dtbl_bucket u_write_bucket (
		.op         (write_op),
		.level      (write_tokens_q),
		.elapsed    (elapsed[dtbl_pkg::CFG_W-1:0]),
		.rate       (regs.write_refill),
		.ceiling    (regs.write_ceil),
		.amount     (amount_s1),
		.level_next (write_next),
		.sat        (write_sat)
	);

	// Commit the state once per item, as it leaves s1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_tokens_q  <= dtbl_pkg::LEVEL_RESET;
			write_tokens_q <= dtbl_pkg::LEVEL_RESET;
			last_tick_q    <= '0;
		end else if (advance) begin
			read_tokens_q  <= read_next;
			write_tokens_q <= write_next;
			if (read_op.refill) begin
				last_tick_q <= tick_s1;
			end
		end
	end

	// Result register: hold until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_level_s2  <= read_next;
			write_level_s2 <= write_next;
			sat_s2         <= read_sat || write_sat;
		end
	end

	assign result.valid       = valid_s2;
	assign result.read_level  = read_level_s2;
	assign result.write_level = write_level_s2;
	assign result.saturated   = sat_s2;

`include "assert_macros.svh"

	`DTBL_ASSERT(a_tick_hold, !(advance && read_op.refill) |=> $stable(last_tick_q), "last tick moved without a refill")
	`DTBL_ASSERT(a_tick_no_sat, (advance && action_s1 == dtbl_pkg::ACT_TICK) |=> !sat_s2, "tick update reported saturation")
	`DTBL_ASSERT(a_ready_when_empty, !valid_s2 |-> item.ready, "input stalled with empty result register")
	`DTBL_ASSERT(a_level_hold, !advance |=> ($stable(read_tokens_q) && $stable(write_tokens_q)), "level changed with no item leaving s1")

endmodule
